@@ rtl/delayed_event_timer_table_core_assert.svh @@
// Assertion helpers for the timer table RTL.
`ifndef DELAYED_EVENT_TIMER_TABLE_CORE_ASSERT_SVH
`define DELAYED_EVENT_TIMER_TABLE_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define DETT_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define DETT_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/dett_pkg.sv @@
`default_nettype none

package dett_pkg;

   // Table size default
   localparam int SLOTS_DEFAULT = 16;

   // Fixed field widths
   localparam int TIME_W       = 32;
   localparam int DELAY_W      = 16;
   localparam int CODE_W       = 8;
   localparam int KIND_W       = 2;
   localparam int SLOT_INDEX_W = 4;

   // Operation codes
   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_ADD_OK     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ADD_REJECT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FIRED      = 2'd2;
   localparam logic [KIND_W-1:0] KIND_DONE       = 2'd3;

   typedef struct packed {
      logic                operation;
      logic [CODE_W-1:0]   event_code;
      logic [DELAY_W-1:0]  delay_ticks;
      logic [TIME_W-1:0]   now_time;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]       result_kind;
      logic [CODE_W-1:0]       fired_code;
      logic [SLOT_INDEX_W-1:0] slot_index;
      logic                    last_result;
   } rsp_type;

   // One table entry as held in the store
   typedef struct packed {
      logic [TIME_W-1:0] deadline;
      logic [CODE_W-1:0] code;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_ACK,
      ST_REJECT,
      ST_SCAN,
      ST_TEST,
      ST_DONE
   } state_type;

   // Deadline = now + delay, saturating at the top of the time range
   function automatic logic [TIME_W-1:0] sat_deadline(
      input logic [TIME_W-1:0]  now_time,
      input logic [DELAY_W-1:0] delay_ticks
   );
      logic [TIME_W:0] sum;
      sum = {1'b0, now_time} + {{(TIME_W-DELAY_W+1){1'b0}}, delay_ticks};
      return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/delayed_event_timer_table_core.sv @@
// Channel   Ports                          Direction  Moves
// request   req_valid req_stall req_data   in         one add or update item
// response  rsp_valid rsp_stall rsp_data   out        one result per transfer
//
// Add: steps from slot 0 past occupied slots to the lowest free slot, fills it
//   and acknowledges; a full table is rejected without a search.
// Update: visits every slot in order; an occupied slot adds a test step, set by
//   the single deadline comparator and the registered read port of the entry store.
// Reset clears the occupancy bits and the count; entries need no clearing.
// A stalled response holds the sequencer at its next result; one finished
//   result waits in the output register while scanning goes on.
`default_nettype none

module delayed_event_timer_table_core import dett_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_stall,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_data
);

   `include "delayed_event_timer_table_core_assert.svh"

   localparam int IdxW = $clog2(SLOTS);
   localparam int CntW = $clog2(SLOTS + 1);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(SLOTS);

   state_type       state_ff, state_in;
   req_type         req_ff;
   logic [IdxW-1:0] scan_ff;
   logic [SLOTS-1:0] active_ff;
   logic [CntW-1:0] count_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_data_ff;

   logic      out_free;
   logic      req_take;
   logic      scan_last;
   logic      slot_busy;
   logic      due;
   logic      rsp_load;
   rsp_type   rsp_next;
   logic      fill;
   logic      fire;
   logic      scan_step;
   entry_type wr_entry;
   entry_type rd_entry;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign scan_last = (scan_ff == LastIdx);
   assign slot_busy = active_ff[scan_ff];
   // Shared comparator: deadline at or before now
   assign due       = (rd_entry.deadline <= req_ff.now_time);

   assign wr_entry.deadline = sat_deadline(req_ff.now_time, req_ff.delay_ticks);
   assign wr_entry.code     = req_ff.event_code;

   dett_store #(
      .SLOTS (SLOTS)
   ) u_store (
      .clock    (clock),
      .wr_en    (fill),
      .addr     (scan_ff),
      .wr_entry (wr_entry),
      .rd_entry (rd_entry)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_data.operation == OP_UPDATE) begin
                  state_in = ST_SCAN;
               end else if (count_ff >= FullCnt) begin
                  state_in = ST_REJECT;
               end else begin
                  state_in = ST_FIND;
               end
            end
         end
         ST_FIND: begin
            if (!slot_busy) begin
               state_in = ST_ACK;
            end
         end
         ST_ACK, ST_REJECT, ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (slot_busy) begin
               state_in = ST_TEST;
            end else if (scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_TEST: begin
            if (!due || out_free) begin
               state_in = scan_last ? ST_DONE : ST_SCAN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      rsp_load  = 1'b0;
      rsp_next  = '0;
      fill      = 1'b0;
      fire      = 1'b0;
      scan_step = 1'b0;
      unique case (state_ff)
         ST_IDLE: ;
         ST_FIND: begin
            fill      = !slot_busy;
            scan_step = slot_busy;
         end
         ST_ACK: begin
            rsp_load             = out_free;
            rsp_next.result_kind = KIND_ADD_OK;
            rsp_next.slot_index  = SLOT_INDEX_W'(scan_ff);
            rsp_next.last_result = 1'b1;
         end
         ST_REJECT: begin
            rsp_load             = out_free;
            rsp_next.result_kind = KIND_ADD_REJECT;
            rsp_next.last_result = 1'b1;
         end
         ST_SCAN: begin
            scan_step = !slot_busy && !scan_last;
         end
         ST_TEST: begin
            fire                 = due && out_free;
            rsp_load             = fire;
            rsp_next.result_kind = KIND_FIRED;
            rsp_next.fired_code  = rd_entry.code;
            rsp_next.slot_index  = SLOT_INDEX_W'(scan_ff);
            scan_step            = (!due || out_free) && !scan_last;
         end
         ST_DONE: begin
            rsp_load             = out_free;
            rsp_next.result_kind = KIND_DONE;
            rsp_next.last_result = 1'b1;
         end
         default: ;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // Occupy or free the slot under scan
         if (fill) begin
            active_ff[scan_ff] <= 1'b1;
            count_ff           <= count_ff + CntW'(1);
         end else if (fire) begin
            active_ff[scan_ff] <= 1'b0;
            count_ff           <= count_ff - CntW'(1);
         end
         // Hold the result until its transfer
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item, scan index and result payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff  <= req_data;
         scan_ff <= '0;
      end else if (scan_step) begin
         scan_ff <= scan_ff + IdxW'(1);
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `DETT_ASSERT(a_count_matches, clock, reset,
      $countones(active_ff) == int'(count_ff),
      "occupancy count differs from occupied slots")
   `DETT_ASSERT(a_find_has_room, clock, reset,
      (state_ff == ST_FIND) |-> (count_ff < FullCnt),
      "free slot search started on a full table")
   `DETT_ASSERT(a_fire_busy_slot, clock, reset, fire |-> slot_busy,
      "fired a slot that is not occupied")
   `DETT_ASSERT(a_no_overwrite, clock, reset,
      rsp_load |-> (!rsp_valid_ff || !rsp_stall),
      "result register overwritten while stalled")
   `DETT_ASSERT_ALWAYS(a_reset_idle, clock,
      reset |=> (state_ff == ST_IDLE && !rsp_valid_ff),
      "sequencer not idle after reset")

endmodule

`default_nettype wire

@@ rtl/dett_store.sv @@
`default_nettype none

module dett_store import dett_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT,
   localparam int IdxW = $clog2(SLOTS)
) (
   input  wire logic            clock,
   input  wire logic            wr_en,
   input  wire logic [IdxW-1:0] addr,
   input  wire entry_type       wr_entry,
   output      entry_type       rd_entry
);

   entry_type entry_mem [SLOTS];
   entry_type rd_entry_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[addr] <= wr_entry;
      end
   end

   // Registered read at the scan address
   always_ff @(posedge clock) begin
      rd_entry_ff <= entry_mem[addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

`default_nettype wire

@@ sim/delayed_event_timer_table_core_tb.sv @@
`timescale 1ns / 1ps

module delayed_event_timer_table_core_tb;
   import dett_pkg::*;

   localparam int TABLE_SLOTS     = SLOTS_DEFAULT;
   localparam int RANDOM_REQUESTS = 250;
   localparam int QUIET_LIMIT     = 4000;
   localparam int TAIL_CYCLES     = 60;

   typedef struct {
      req_type item;
      bit      drain_first;
   } queued_request_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Predicted table contents
   logic [TIME_W-1:0] slot_deadline [TABLE_SLOTS];
   logic [CODE_W-1:0] slot_code [TABLE_SLOTS];
   bit                slot_busy [TABLE_SLOTS];
   int                busy_count;

   queued_request_type queued_requests[$];
   rsp_type            due_results[$];

   logic req_taken = 1'b0;
   int   quiet_cycles = 0;
   int   failures = 0;
   int   req_gap = 0;
   int   stall_left = 0;
   bit   req_calm = 1'b0;
   bit   rsp_calm = 1'b0;
   bit   timed_out = 1'b0;

   delayed_event_timer_table_core #(.SLOTS(TABLE_SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void queue_request(input logic op, input int code, input int delay,
                                         input logic [TIME_W-1:0] now, input bit drain);
      queued_request_type q;
      q.item.operation   = op;
      q.item.event_code  = code[CODE_W-1:0];
      q.item.delay_ticks = delay[DELAY_W-1:0];
      q.item.now_time    = now;
      q.drain_first      = drain;
      queued_requests.push_back(q);
   endfunction

   // Place an event or fire expired ones, queueing the results this item causes
   function automatic void advance_timer_table(input req_type item);
      rsp_type         r;
      int              free_slot;
      int              i;
      logic [TIME_W:0] sum;
      if (item.operation == OP_ADD) begin
         free_slot = -1;
         r = '0;
         r.last_result = 1'b1;
         if (busy_count < TABLE_SLOTS) begin
            for (i = TABLE_SLOTS - 1; i >= 0; i--) begin
               if (!slot_busy[i]) free_slot = i;
            end
         end
         if (free_slot < 0) begin
            r.result_kind = KIND_ADD_REJECT;
         end else begin
            sum = {1'b0, item.now_time} + (TIME_W+1)'(item.delay_ticks);
            slot_deadline[free_slot] = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
            slot_code[free_slot]     = item.event_code;
            slot_busy[free_slot]     = 1'b1;
            busy_count++;
            r.result_kind = KIND_ADD_OK;
            r.slot_index  = free_slot[SLOT_INDEX_W-1:0];
         end
         due_results.push_back(r);
      end else begin
         for (i = 0; i < TABLE_SLOTS; i++) begin
            if (slot_busy[i] && slot_deadline[i] <= item.now_time) begin
               slot_busy[i] = 1'b0;
               if (busy_count > 0) busy_count--;
               r = '0;
               r.result_kind = KIND_FIRED;
               r.fired_code  = slot_code[i];
               r.slot_index  = i[SLOT_INDEX_W-1:0];
               due_results.push_back(r);
            end
         end
         r = '0;
         r.result_kind = KIND_DONE;
         r.last_result = 1'b1;
         due_results.push_back(r);
      end
   endfunction

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         failures++;
      end
   endfunction

   // Present requests; hold each until it is taken
   always @(negedge clock) begin
      logic               next_valid;
      req_type            next_data;
      queued_request_type head;
      next_valid = req_valid;
      next_data  = req_data;
      if ($urandom_range(0, 199) == 0) req_calm = ~req_calm;
      if (req_valid && req_taken) next_valid = 1'b0;
      if (!reset && !next_valid) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (queued_requests.size() > 0 &&
                      !(queued_requests[0].drain_first && due_results.size() != 0)) begin
            head       = queued_requests.pop_front();
            next_data  = head.item;
            next_valid = 1'b1;
            req_gap    = pick_gap(req_calm);
         end
      end
      req_valid <= next_valid;
      req_data  <= next_data;
   end

   // Stall the result channel in random bursts
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) rsp_calm = ~rsp_calm;
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = pick_gap(rsp_calm);
      end
   end

   // Check each result transfer, then record the request transfer
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               $display("%0t: no result expected, got kind %0d code %0d slot %0d last %0d",
                        $time, rsp_data.result_kind, rsp_data.fired_code,
                        rsp_data.slot_index, rsp_data.last_result);
               failures++;
            end else begin
               want = due_results.pop_front();
               compare_field("result_kind", want.result_kind, rsp_data.result_kind);
               compare_field("fired_code", want.fired_code, rsp_data.fired_code);
               compare_field("slot_index", want.slot_index, rsp_data.slot_index);
               compare_field("last_result", want.last_result, rsp_data.last_result);
            end
         end
         if (req_valid && !req_stall) advance_timer_table(req_data);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [TIME_W-1:0] clock_now;
      int                r;
      int                delay;
      int                n;
      busy_count = 0;
      for (n = 0; n < TABLE_SLOTS; n++) slot_busy[n] = 1'b0;

      // Directed: empty update, zero delay, deadline saturation, full table
      queue_request(OP_UPDATE, 8'h5A, 16'h1234, 32'd0, 1'b0);
      queue_request(OP_ADD, 8'h00, 16'h0000, 32'd0, 1'b0);
      queue_request(OP_ADD, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      queue_request(OP_ADD, 8'hAA, 16'hFFFF, 32'hFFFF_0001, 1'b0);
      queue_request(OP_ADD, 8'h55, 16'hFFFF, 32'hFFFF_0000, 1'b0);
      // Fields other than the time are ignored here
      queue_request(OP_UPDATE, 8'hFF, 16'hFFFF, 32'd0, 1'b0);
      for (n = 0; n < 13; n++) queue_request(OP_ADD, 8'h10 + n, n * 10, 32'd1000, 1'b0);
      queue_request(OP_ADD, 8'hEE, 16'd5, 32'd1000, 1'b0);
      queue_request(OP_UPDATE, 8'h00, 16'h0000, 32'hFFFF_FFFF, 1'b0);

      // Random: mostly a steadily advancing clock, some jumps as noise
      clock_now = $urandom_range(0, 5000);
      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         r = $urandom_range(0, 99);
         if (r < 80) clock_now = clock_now + $urandom_range(0, 150);
         else if (r >= 96) clock_now = 32'hFFFF_FFFF - $urandom_range(0, 500);
         else if (r >= 90) clock_now = $urandom;
         r = $urandom_range(0, 99);
         if (r < 70) delay = $urandom_range(0, 400);
         else if (r < 90) delay = $urandom_range(0, 65535);
         else if (r < 95) delay = 65535;
         else delay = 0;
         queue_request($urandom_range(0, 99) < 55 ? OP_ADD : OP_UPDATE, $urandom_range(0, 255),
                       delay, clock_now, n == 0 || n == RANDOM_REQUESTS / 2);
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      fork
         begin
            while (queued_requests.size() != 0 || req_valid || due_results.size() != 0)
               @(posedge clock);
            repeat (TAIL_CYCLES) @(posedge clock);
         end
         begin
            wait (quiet_cycles >= QUIET_LIMIT);
            timed_out = 1'b1;
         end
      join_any

      if (timed_out) begin
         $display("[delayed_event_timer_table_core] ERROR");
      end else if (failures == 0) begin
         $display("[delayed_event_timer_table_core] OK");
      end else begin
         $display("[delayed_event_timer_table_core] ERROR");
      end
      $finish;
   end

endmodule
